// ===== src/ndrm_pkg.sv =====
// ----------------------------------------------------------------------------
// ndrm_pkg
// Shared types and constants of the descriptor ring manager: command and
// status codes, descriptor word bit positions and the register set.
// ----------------------------------------------------------------------------
package ndrm_pkg;

   // ring depths
   localparam int TX_RING_DEPTH_DEF = 64;
   localparam int RX_RING_DEPTH_DEF = 64;

   // field widths
   localparam int CMD_W    = 2;
   localparam int LEN_W    = 14;
   localparam int WORD_W   = 32;
   localparam int CAP_W    = 16;
   localparam int STAT_W   = 3;
   localparam int ENTRY_W  = 6;
   localparam int CSR_IDX_W = 2;

   // commands
   localparam logic [CMD_W-1:0] CMD_SEND    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REAP    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RECEIVE = 2'd2;

   // result status codes
   localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
   localparam logic [STAT_W-1:0] STAT_NOT_READY = 3'd1;
   localparam logic [STAT_W-1:0] STAT_BAD_LEN   = 3'd2;
   localparam logic [STAT_W-1:0] STAT_FULL      = 3'd3;
   localparam logic [STAT_W-1:0] STAT_OWNED     = 3'd4;
   localparam logic [STAT_W-1:0] STAT_NONE      = 3'd5;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE         = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAD_LENGTH     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TX_MAX_LENGTH  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RX_BUFFER_SIZE = 2'd3;

   // register reset values
   localparam logic [LEN_W-1:0] PAD_LENGTH_RST     = 14'd60;
   localparam logic [LEN_W-1:0] TX_MAX_LENGTH_RST  = 14'd2048;
   localparam logic [LEN_W-1:0] RX_BUFFER_SIZE_RST = 14'd2048;

   // frame limits
   localparam logic [LEN_W-1:0] MIN_FRAME = 14'd14;
   localparam logic [LEN_W-1:0] CRC_BYTES = 14'd4;

   // descriptor word bits
   localparam int BIT_OWN   = 31;
   localparam int BIT_EOR   = 30;
   localparam int BIT_FIRST = 29;
   localparam int BIT_LAST  = 28;
   localparam int BIT_RXERR = 21;

   typedef struct packed {
      logic             enable;
      logic [LEN_W-1:0] pad_length;
      logic [LEN_W-1:0] tx_max_length;
      logic [LEN_W-1:0] rx_buffer_size;
   } cfg_type;

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

endpackage

// ===== src/ndrm_csr_regs.sv =====
// ----------------------------------------------------------------------------
// ndrm_csr_regs
// Configuration register file, written through the csr channel.
// ----------------------------------------------------------------------------
module ndrm_csr_regs
   import ndrm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]    csr_wdata,
   output cfg_type              cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // register decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_ENABLE:         cfg_in.enable         = csr_wdata[0];
            CSR_PAD_LENGTH:     cfg_in.pad_length     = csr_wdata[LEN_W-1:0];
            CSR_TX_MAX_LENGTH:  cfg_in.tx_max_length  = csr_wdata[LEN_W-1:0];
            CSR_RX_BUFFER_SIZE: cfg_in.rx_buffer_size = csr_wdata[LEN_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable         <= 1'b0;
         cfg_ff.pad_length     <= PAD_LENGTH_RST;
         cfg_ff.tx_max_length  <= TX_MAX_LENGTH_RST;
         cfg_ff.rx_buffer_size <= RX_BUFFER_SIZE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== src/ndrm_busy_ram.sv =====
// ----------------------------------------------------------------------------
// ndrm_busy_ram
// One-bit-wide synchronous memory holding the transmit entry busy flags,
// one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ndrm_busy_ram
   import ndrm_pkg::*;
#(
   parameter int DEPTH = TX_RING_DEPTH_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic          wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic          rd_data
);

   logic mem [DEPTH];
   logic rd_data_ff;

   assign rd_data = rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

// ===== src/nic_descriptor_ring_manager.sv =====
// ----------------------------------------------------------------------------
// nic_descriptor_ring_manager
// Transmit and receive descriptor ring bookkeeping: send, reap and receive
// commands against a busy-flag memory and three ring indexes.
// ----------------------------------------------------------------------------
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_ready | command, frame_length,
//           |           |                       | desc_status, max_length
//   rsp     | out       | rsp_valid / rsp_ready | status, entry, desc_word, length
//   csr     | in        | csr_valid / csr_ready | csr_index, csr_wdata
//
// A request is accepted in the idle state, where the busy-flag memory is read
// at the accepting edge; the result is formed and written back in the execute
// step, and no new request is taken until that step is done.
// After reset the busy memory is cleared entry by entry, during which
// req_ready is low; csr writes are taken at any time.
// A stalled response holds the result; the next request is still accepted
// and waits in the execute step until the response register is free.
// ----------------------------------------------------------------------------
module nic_descriptor_ring_manager
   import ndrm_pkg::*;
#(
   parameter int TX_RING_DEPTH = TX_RING_DEPTH_DEF,
   parameter int RX_RING_DEPTH = RX_RING_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [CMD_W-1:0]     req_command,
   input  logic [LEN_W-1:0]     req_frame_length,
   input  logic [WORD_W-1:0]    req_desc_status,
   input  logic [CAP_W-1:0]     req_max_length,
   // response channel
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [STAT_W-1:0]    rsp_status,
   output logic [ENTRY_W-1:0]   rsp_entry,
   output logic [WORD_W-1:0]    rsp_desc_word,
   output logic [LEN_W-1:0]     rsp_length,
   // configuration channel
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]    csr_wdata
);

   localparam int TW = $clog2(TX_RING_DEPTH);
   localparam int RW = $clog2(RX_RING_DEPTH);
   localparam logic [TW-1:0] TX_LAST = TW'(TX_RING_DEPTH - 1);
   localparam logic [RW-1:0] RX_LAST = RW'(RX_RING_DEPTH - 1);

   cfg_type cfg;

   state_type state_ff, state_in;

   logic [TW-1:0] tx_producer_ff, tx_producer_in;
   logic [TW-1:0] tx_cleanup_ff, tx_cleanup_in;
   logic [RW-1:0] rx_consumer_ff, rx_consumer_in;

   logic          clearing_ff, clearing_in;
   logic [TW-1:0] clear_idx_ff, clear_idx_in;

   // captured request
   logic [CMD_W-1:0]  cmd_ff;
   logic [LEN_W-1:0]  flen_ff;
   logic [WORD_W-1:0] dstat_ff;
   logic [CAP_W-1:0]  cap_ff;

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0] rsp_status_ff, rsp_status_in;
   logic [ENTRY_W-1:0] rsp_entry_ff, rsp_entry_in;
   logic [WORD_W-1:0] rsp_desc_word_ff, rsp_desc_word_in;
   logic [LEN_W-1:0]  rsp_length_ff, rsp_length_in;

   // busy memory ports
   logic          busy_rd;
   logic          busy_wr_en, exec_wr_en;
   logic [TW-1:0] busy_wr_addr;
   logic          busy_wr_data, exec_wr_data;
   logic          req_accept;
   logic          rsp_free;
   logic          exec_fire;

   // receive length path
   logic [LEN_W-1:0] rx_len_raw;
   logic [LEN_W-1:0] rx_len_crc;
   logic [LEN_W-1:0] plen;

   ndrm_csr_regs u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // clearing pass owns the write port until done
   assign busy_wr_en   = clearing_ff | exec_wr_en;
   assign busy_wr_addr = clearing_ff ? clear_idx_ff
                         : ((cmd_ff == CMD_REAP) ? tx_cleanup_ff : tx_producer_ff);
   assign busy_wr_data = clearing_ff ? 1'b0 : exec_wr_data;

   ndrm_busy_ram #(
      .DEPTH (TX_RING_DEPTH),
      .AW    (TW)
   ) u_busy_ram (
      .clock   (clock),
      .wr_en   (busy_wr_en),
      .wr_addr (busy_wr_addr),
      .wr_data (busy_wr_data),
      .rd_en   (req_accept),
      .rd_addr ((req_command == CMD_REAP) ? tx_cleanup_ff : tx_producer_ff),
      .rd_data (busy_rd)
   );

   assign req_ready  = (state_ff == S_IDLE) & ~clearing_ff;
   assign req_accept = req_valid & req_ready;
   assign rsp_free   = ~rsp_valid_ff | rsp_ready;
   assign exec_fire  = (state_ff == S_EXEC) & rsp_free;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_entry     = rsp_entry_ff;
   assign rsp_desc_word = rsp_desc_word_ff;
   assign rsp_length    = rsp_length_ff;

   // receive length: crc strip on good frames, then clamp to capacity
   assign rx_len_raw = dstat_ff[LEN_W-1:0];
   always_comb begin
      if (dstat_ff[BIT_RXERR] || (rx_len_raw == '0)) begin
         rx_len_crc = '0;
      end else if (rx_len_raw >= CRC_BYTES) begin
         rx_len_crc = rx_len_raw - CRC_BYTES;
      end else begin
         rx_len_crc = rx_len_raw;
      end
   end

   // transmit padding
   assign plen = (flen_ff < cfg.pad_length) ? cfg.pad_length : flen_ff;

   // clearing pass sequencing
   always_comb begin
      clearing_in  = clearing_ff;
      clear_idx_in = clear_idx_ff;
      if (clearing_ff) begin
         if (clear_idx_ff == TX_LAST) begin
            clearing_in = 1'b0;
         end else begin
            clear_idx_in = clear_idx_ff + 1'b1;
         end
      end
   end

   // next state, execute step and response load
   always_comb begin
      state_in         = state_ff;
      tx_producer_in   = tx_producer_ff;
      tx_cleanup_in    = tx_cleanup_ff;
      rx_consumer_in   = rx_consumer_ff;
      exec_wr_en       = 1'b0;
      exec_wr_data     = 1'b0;
      rsp_valid_in     = rsp_valid_ff & ~rsp_ready;
      rsp_status_in    = rsp_status_ff;
      rsp_entry_in     = rsp_entry_ff;
      rsp_desc_word_in = rsp_desc_word_ff;
      rsp_length_in    = rsp_length_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (exec_fire) begin
               state_in         = S_IDLE;
               rsp_valid_in     = 1'b1;
               rsp_status_in    = STAT_NONE;
               rsp_entry_in     = '0;
               rsp_desc_word_in = '0;
               rsp_length_in    = '0;
               if (!cfg.enable) begin
                  rsp_status_in = STAT_NOT_READY;
               end else begin
                  case (cmd_ff)
                     CMD_SEND: begin
                        rsp_entry_in = ENTRY_W'(tx_producer_ff);
                        if ((flen_ff < MIN_FRAME) || (flen_ff > cfg.tx_max_length)) begin
                           rsp_status_in = STAT_BAD_LEN;
                        end else if (busy_rd) begin
                           rsp_status_in = STAT_FULL;
                        end else begin
                           rsp_status_in                 = STAT_OK;
                           rsp_length_in                 = plen;
                           rsp_desc_word_in[LEN_W-1:0]   = plen;
                           rsp_desc_word_in[BIT_OWN]     = 1'b1;
                           rsp_desc_word_in[BIT_FIRST]   = 1'b1;
                           rsp_desc_word_in[BIT_LAST]    = 1'b1;
                           rsp_desc_word_in[BIT_EOR]     = (tx_producer_ff == TX_LAST);
                           exec_wr_en                    = 1'b1;
                           exec_wr_data                  = 1'b1;
                           tx_producer_in = (tx_producer_ff == TX_LAST) ? '0
                                            : tx_producer_ff + 1'b1;
                        end
                     end
                     CMD_REAP: begin
                        rsp_entry_in = ENTRY_W'(tx_cleanup_ff);
                        if (!busy_rd) begin
                           rsp_status_in = STAT_NONE;
                        end else if (dstat_ff[BIT_OWN]) begin
                           rsp_status_in = STAT_OWNED;
                        end else begin
                           rsp_status_in = STAT_OK;
                           exec_wr_en    = 1'b1;
                           exec_wr_data  = 1'b0;
                           tx_cleanup_in = (tx_cleanup_ff == TX_LAST) ? '0
                                           : tx_cleanup_ff + 1'b1;
                        end
                     end
                     CMD_RECEIVE: begin
                        rsp_entry_in = ENTRY_W'(rx_consumer_ff);
                        if (cap_ff == '0) begin
                           rsp_status_in = STAT_BAD_LEN;
                        end else if (dstat_ff[BIT_OWN]) begin
                           rsp_status_in = STAT_OWNED;
                        end else begin
                           rsp_status_in = STAT_OK;
                           rsp_length_in = ({2'b00, rx_len_crc} > cap_ff)
                                           ? cap_ff[LEN_W-1:0] : rx_len_crc;
                           rsp_desc_word_in[LEN_W-1:0] = cfg.rx_buffer_size;
                           rsp_desc_word_in[BIT_OWN]   = 1'b1;
                           rsp_desc_word_in[BIT_EOR]   = (rx_consumer_ff == RX_LAST);
                           rx_consumer_in = (rx_consumer_ff == RX_LAST) ? '0
                                            : rx_consumer_ff + 1'b1;
                        end
                     end
                     default: begin
                        rsp_status_in = STAT_NONE;
                     end
                  endcase
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         tx_producer_ff <= '0;
         tx_cleanup_ff  <= '0;
         rx_consumer_ff <= '0;
         clearing_ff    <= 1'b1;
         clear_idx_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         tx_producer_ff <= tx_producer_in;
         tx_cleanup_ff  <= tx_cleanup_in;
         rx_consumer_ff <= rx_consumer_in;
         clearing_ff    <= clearing_in;
         clear_idx_ff   <= clear_idx_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // request capture and response payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         cmd_ff   <= req_command;
         flen_ff  <= req_frame_length;
         dstat_ff <= req_desc_status;
         cap_ff   <= req_max_length;
      end
      rsp_status_ff    <= rsp_status_in;
      rsp_entry_ff     <= rsp_entry_in;
      rsp_desc_word_ff <= rsp_desc_word_in;
      rsp_length_ff    <= rsp_length_in;
   end

endmodule

// ===== src/ndrm_checker.sv =====
// ----------------------------------------------------------------------------
// ndrm_checker
// Port-level checks on the response channel of the descriptor ring manager,
// bound to the top level.
// ----------------------------------------------------------------------------
module ndrm_checker
   import ndrm_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [STAT_W-1:0]  rsp_status,
   input logic [ENTRY_W-1:0] rsp_entry,
   input logic [WORD_W-1:0]  rsp_desc_word,
   input logic [LEN_W-1:0]   rsp_length
);

   // a stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_entry) && $stable(rsp_desc_word) && $stable(rsp_length))
      else $error("response changed while stalled");

   // status code stays in the defined range
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= STAT_NONE)
      else $error("undefined response status");

   // refused commands carry no descriptor word and no length
   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STAT_OK) |-> (rsp_desc_word == '0) && (rsp_length == '0))
      else $error("refused request carries payload");

   // not ready reports entry zero
   a_not_ready_entry: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STAT_NOT_READY) |-> rsp_entry == '0)
      else $error("not ready with nonzero entry");

   // a successful reap has no owned word and no length
   a_reap_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STAT_OK) && !rsp_desc_word[BIT_OWN]
         |-> (rsp_length == '0) && (rsp_desc_word == '0))
      else $error("reap result carries payload");

endmodule

bind nic_descriptor_ring_manager ndrm_checker u_ndrm_checker (.*);
